[rtl/core/uihb_pkg.sv]
// shared types, constants and register map of the udp/ipv4 header builder
package uihb_pkg;

    localparam int HDR_MAX  = 46;   // header bytes with an 802.1q tag
    localparam int HDR_BASE = 42;   // header bytes without a tag
    localparam int IDX_W    = 6;
    localparam int TAIL_LEN = 30;   // ethertype + ip + udp bytes
    localparam int TAIL_W   = 5;
    localparam int SUM_W    = 19;   // room for seven 16-bit words

    localparam logic [15:0] ETH_LEN   = 16'd14;
    localparam logic [15:0] TAG_LEN   = 16'd4;
    localparam logic [15:0] IP_LEN    = 16'd20;
    localparam logic [15:0] UDP_LEN   = 16'd8;
    localparam logic [15:0] TPID_TAG  = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  VER_IHL   = 8'h45;
    localparam logic [7:0]  PROTO_UDP = 8'h11;

    // register indexes, each at byte address 8*index
    localparam logic [2:0] REG_DST_MAC      = 3'd0;
    localparam logic [2:0] REG_SRC_MAC      = 3'd1;
    localparam logic [2:0] REG_IP_ADDRESSES = 3'd2;
    localparam logic [2:0] REG_UDP_PORTS    = 3'd3;
    localparam logic [2:0] REG_TTL_TOS      = 3'd4;
    localparam logic [2:0] REG_VLAN_ENABLE  = 3'd5;
    localparam logic [2:0] REG_VLAN_PCP     = 3'd6;
    localparam logic [2:0] REG_VLAN_ID      = 3'd7;

    localparam logic [47:0] RST_DST_MAC      = 48'h030000000000;
    localparam logic [47:0] RST_SRC_MAC      = 48'h020000000020;
    localparam logic [63:0] RST_IP_ADDRESSES = 64'h0A000000E0E00000;
    localparam logic [31:0] RST_UDP_PORTS    = 32'h00640064;
    localparam logic [15:0] RST_TTL_TOS      = 16'h0100;
    localparam logic        RST_VLAN_ENABLE  = 1'b0;
    localparam logic [2:0]  RST_VLAN_PCP     = 3'd0;
    localparam logic [11:0] RST_VLAN_ID      = 12'd100;

    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [63:0] ip_addresses;
        logic [31:0] udp_ports;
        logic [15:0] ttl_tos;
        logic        vlan_enable;
        logic [2:0]  vlan_pcp;
        logic [11:0] vlan_id;
    } t_cfg;

    // one header byte as it travels down the cell row
    typedef struct packed {
        logic             vld;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             short_flag;
    } t_cell;

endpackage

[rtl/core/uihb_cfg.sv]
// apb register file holding the header configuration
module uihb_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [5:0]           i_paddr,
    input  logic [63:0]          i_pwdata,
    output logic [63:0]          o_prdata,
    output logic                 o_pready,
    output uihb_pkg::t_cfg       o_cfg
);

    uihb_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [2:0]     w_sel;

    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign w_sel    = i_paddr[5:3];
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dst_mac      <= uihb_pkg::RST_DST_MAC;
            r_cfg.src_mac      <= uihb_pkg::RST_SRC_MAC;
            r_cfg.ip_addresses <= uihb_pkg::RST_IP_ADDRESSES;
            r_cfg.udp_ports    <= uihb_pkg::RST_UDP_PORTS;
            r_cfg.ttl_tos      <= uihb_pkg::RST_TTL_TOS;
            r_cfg.vlan_enable  <= uihb_pkg::RST_VLAN_ENABLE;
            r_cfg.vlan_pcp     <= uihb_pkg::RST_VLAN_PCP;
            r_cfg.vlan_id      <= uihb_pkg::RST_VLAN_ID;
        end else if (w_wr) begin
            unique case (w_sel)
                uihb_pkg::REG_DST_MAC:      r_cfg.dst_mac      <= i_pwdata[47:0];
                uihb_pkg::REG_SRC_MAC:      r_cfg.src_mac      <= i_pwdata[47:0];
                uihb_pkg::REG_IP_ADDRESSES: r_cfg.ip_addresses <= i_pwdata;
                uihb_pkg::REG_UDP_PORTS:    r_cfg.udp_ports    <= i_pwdata[31:0];
                uihb_pkg::REG_TTL_TOS:      r_cfg.ttl_tos      <= i_pwdata[15:0];
                uihb_pkg::REG_VLAN_ENABLE:  r_cfg.vlan_enable  <= i_pwdata[0];
                uihb_pkg::REG_VLAN_PCP:     r_cfg.vlan_pcp     <= i_pwdata[2:0];
                uihb_pkg::REG_VLAN_ID:      r_cfg.vlan_id      <= i_pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            uihb_pkg::REG_DST_MAC:      o_prdata = {16'd0, r_cfg.dst_mac};
            uihb_pkg::REG_SRC_MAC:      o_prdata = {16'd0, r_cfg.src_mac};
            uihb_pkg::REG_IP_ADDRESSES: o_prdata = r_cfg.ip_addresses;
            uihb_pkg::REG_UDP_PORTS:    o_prdata = {32'd0, r_cfg.udp_ports};
            uihb_pkg::REG_TTL_TOS:      o_prdata = {48'd0, r_cfg.ttl_tos};
            uihb_pkg::REG_VLAN_ENABLE:  o_prdata = {63'd0, r_cfg.vlan_enable};
            uihb_pkg::REG_VLAN_PCP:     o_prdata = {61'd0, r_cfg.vlan_pcp};
            uihb_pkg::REG_VLAN_ID:      o_prdata = {52'd0, r_cfg.vlan_id};
            default:                    o_prdata = 64'd0;
        endcase
    end

endmodule

[rtl/core/uihb_frame_prep.sv]
// per-frame length and checksum pipeline that assembles the header bytes
module uihb_frame_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uihb_pkg::t_cfg    i_cfg,
    input  logic              i_in_vld,
    input  logic [15:0]       i_in_size,
    output logic              o_in_rdy,
    input  logic              i_load,
    output logic              o_frame_vld,
    output uihb_pkg::t_cell   o_load_cells [uihb_pkg::HDR_MAX]
);

    // stage 0: captured request
    logic        r_s0_vld;
    logic [15:0] r_s0_size;
    // stage 1: lengths and partial checksum
    logic                      r_s1_vld;
    logic [15:0]               r_ip_total;
    logic [15:0]               r_udp_total;
    logic                      r_short;
    logic [uihb_pkg::SUM_W-1:0] r_sum;

    logic                       w_s1_take;
    logic [15:0]                w_l2;
    logic [15:0]                w_hdr_len;
    logic [uihb_pkg::SUM_W-1:0] w_cfg_sum;
    logic [uihb_pkg::SUM_W-1:0] w_sum;
    logic [16:0]                w_fold1;
    logic [15:0]                w_fold2;
    logic [15:0]                w_csum;
    logic [7:0]                 w_tail [uihb_pkg::TAIL_LEN];
    logic [5:0]                 w_total;
    logic [15:0]                w_tci;
    logic [31:0]                w_src_ip;
    logic [31:0]                w_dst_ip;

    assign w_s1_take   = r_s0_vld & (~r_s1_vld | i_load);
    assign o_in_rdy    = ~r_s0_vld | w_s1_take;
    assign o_frame_vld = r_s1_vld;

    assign w_src_ip  = i_cfg.ip_addresses[63:32];
    assign w_dst_ip  = i_cfg.ip_addresses[31:0];
    assign w_l2      = i_cfg.vlan_enable ? (uihb_pkg::ETH_LEN + uihb_pkg::TAG_LEN)
                                         : uihb_pkg::ETH_LEN;
    assign w_hdr_len = w_l2 + uihb_pkg::IP_LEN + uihb_pkg::UDP_LEN;

    // fixed part of the ip checksum: every nonzero header word except total length
    assign w_cfg_sum = uihb_pkg::SUM_W'({uihb_pkg::VER_IHL, i_cfg.ttl_tos[7:0]})
                     + uihb_pkg::SUM_W'({i_cfg.ttl_tos[15:8], uihb_pkg::PROTO_UDP})
                     + uihb_pkg::SUM_W'(w_src_ip[31:16])
                     + uihb_pkg::SUM_W'(w_src_ip[15:0])
                     + uihb_pkg::SUM_W'(w_dst_ip[31:16])
                     + uihb_pkg::SUM_W'(w_dst_ip[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            if (o_in_rdy) begin
                r_s0_vld <= i_in_vld;
            end
            if (w_s1_take) begin
                r_s1_vld <= 1'b1;
            end else if (i_load) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_rdy) begin
            r_s0_size <= i_in_size;
        end
        if (w_s1_take) begin
            r_ip_total  <= r_s0_size - w_l2;
            r_udp_total <= r_s0_size - w_l2 - uihb_pkg::IP_LEN;
            r_short     <= (r_s0_size < w_hdr_len);
            r_sum       <= w_cfg_sum;
        end
    end

    // end-around carry fold, two passes leave no carry
    assign w_sum   = r_sum + uihb_pkg::SUM_W'(r_ip_total);
    assign w_fold1 = {1'b0, w_sum[15:0]} + 17'(w_sum[uihb_pkg::SUM_W-1:16]);
    assign w_fold2 = w_fold1[15:0] + 16'(w_fold1[16]);
    assign w_csum  = ~w_fold2;

    assign w_tci   = {i_cfg.vlan_pcp, 1'b0, i_cfg.vlan_id};
    assign w_total = i_cfg.vlan_enable ? 6'(uihb_pkg::HDR_MAX) : 6'(uihb_pkg::HDR_BASE);

    always_comb begin
        w_tail[0]  = uihb_pkg::TYPE_IPV4[15:8];
        w_tail[1]  = uihb_pkg::TYPE_IPV4[7:0];
        w_tail[2]  = uihb_pkg::VER_IHL;
        w_tail[3]  = i_cfg.ttl_tos[7:0];
        w_tail[4]  = r_ip_total[15:8];
        w_tail[5]  = r_ip_total[7:0];
        w_tail[6]  = 8'd0;
        w_tail[7]  = 8'd0;
        w_tail[8]  = 8'd0;
        w_tail[9]  = 8'd0;
        w_tail[10] = i_cfg.ttl_tos[15:8];
        w_tail[11] = uihb_pkg::PROTO_UDP;
        w_tail[12] = w_csum[15:8];
        w_tail[13] = w_csum[7:0];
        w_tail[14] = w_src_ip[31:24];
        w_tail[15] = w_src_ip[23:16];
        w_tail[16] = w_src_ip[15:8];
        w_tail[17] = w_src_ip[7:0];
        w_tail[18] = w_dst_ip[31:24];
        w_tail[19] = w_dst_ip[23:16];
        w_tail[20] = w_dst_ip[15:8];
        w_tail[21] = w_dst_ip[7:0];
        w_tail[22] = i_cfg.udp_ports[31:24];
        w_tail[23] = i_cfg.udp_ports[23:16];
        w_tail[24] = i_cfg.udp_ports[15:8];
        w_tail[25] = i_cfg.udp_ports[7:0];
        w_tail[26] = r_udp_total[15:8];
        w_tail[27] = r_udp_total[7:0];
        w_tail[28] = 8'd0;
        w_tail[29] = 8'd0;
    end

    always_comb begin
        for (int k = 0; k < uihb_pkg::HDR_MAX; k++) begin
            o_load_cells[k].vld        = (6'(k) < w_total);
            o_load_cells[k].idx        = uihb_pkg::IDX_W'(k);
            o_load_cells[k].last       = (6'(k) == (w_total - 6'd1));
            o_load_cells[k].short_flag = r_short;
            if (k < 6) begin
                o_load_cells[k].data = i_cfg.dst_mac[8*(5-k) +: 8];
            end else if (k < 12) begin
                o_load_cells[k].data = i_cfg.src_mac[8*(11-k) +: 8];
            end else if (i_cfg.vlan_enable) begin
                if (k == 12) begin
                    o_load_cells[k].data = uihb_pkg::TPID_TAG[15:8];
                end else if (k == 13) begin
                    o_load_cells[k].data = uihb_pkg::TPID_TAG[7:0];
                end else if (k == 14) begin
                    o_load_cells[k].data = w_tci[15:8];
                end else if (k == 15) begin
                    o_load_cells[k].data = w_tci[7:0];
                end else begin
                    o_load_cells[k].data = w_tail[uihb_pkg::TAIL_W'(k - 16)];
                end
            end else if (k < uihb_pkg::HDR_BASE) begin
                o_load_cells[k].data = w_tail[uihb_pkg::TAIL_W'(k - 12)];
            end else begin
                o_load_cells[k].data = 8'd0;
            end
        end
    end

endmodule

[rtl/core/uihb_cell.sv]
// one byte cell of the header shift row
module uihb_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_shift,
    input  uihb_pkg::t_cell   i_load_cell,
    input  uihb_pkg::t_cell   i_next,
    output uihb_pkg::t_cell   o_cell
);

    uihb_pkg::t_cell r_cell;

    assign o_cell = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_load) begin
            r_cell <= i_load_cell;
        end else if (i_shift) begin
            r_cell <= i_next;
        end
    end

endmodule

[rtl/core/udp_ipv4_header_builder.sv]
// top level of the ethernet/ipv4/udp header builder
//
// Each request on the slave stream carries one frame length (bytes,
// headers included). The block answers with that frame's header in
// wire order, one byte per output request: 42 bytes, or 46 when the 802.1Q
// tag is enabled. tdata carries the byte and its index, tlast marks the
// final byte and tuser is set on every byte of a frame whose length is
// shorter than the header (the ip and udp lengths are then taken modulo 65536).
// Requests pass a capture register and a length/checksum stage, then the
// whole header is loaded at once into a row of 46 byte cells that
// shifts one byte toward the output each cycle the sink takes one. Cell 0
// is the output register. The next header loads on the same edge that the
// last byte of the current one leaves, so with a ready sink the output
// runs at one byte per cycle, set by the single byte lane at the end of
// the cell row. Two further requests can wait inside.
// Configuration is written over apb at byte address 8*index and should
// only change while no frame is in flight.
module udp_ipv4_header_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: tdata[15:0] = frame length
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    // master stream: tdata[7:0] = header_byte, [13:8] = byte_index, [15:14] = 0
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // tuser[0] = too_short
    output logic        o_m_axis_tuser,
    // apb configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [5:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready
);

    uihb_pkg::t_cfg  w_cfg;
    uihb_pkg::t_cell w_load_cells [uihb_pkg::HDR_MAX];
    uihb_pkg::t_cell w_cells      [uihb_pkg::HDR_MAX];
    logic            w_frame_vld;
    logic            w_load;
    logic            w_shift;

    // register file
    uihb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // lengths, checksum and byte assembly
    uihb_frame_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_vld     (i_s_axis_tvalid),
        .i_in_size    (i_s_axis_tdata),
        .o_in_rdy     (o_s_axis_tready),
        .i_load       (w_load),
        .o_frame_vld  (w_frame_vld),
        .o_load_cells (w_load_cells)
    );

    // the row is filled from cell 0 and shifts as one, so an empty cell 0
    // means an empty row; a new header may also drop in as the last byte
    // of the current one is taken
    assign w_shift = ~w_cells[0].vld | i_m_axis_tready;
    assign w_load  = w_frame_vld &
                     (~w_cells[0].vld | (w_cells[0].last & i_m_axis_tready));

    for (genvar g = 0; g < uihb_pkg::HDR_MAX; g++) begin : g_cell
        uihb_pkg::t_cell w_next;

        // the far end of the row takes in empty cells
        if (g == uihb_pkg::HDR_MAX - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cells[g+1];
        end

        uihb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load),
            .i_shift     (w_shift),
            .i_load_cell (w_load_cells[g]),
            .i_next      (w_next),
            .o_cell      (w_cells[g])
        );
    end

    // cell 0 drives the master stream directly
    assign o_m_axis_tvalid = w_cells[0].vld;
    assign o_m_axis_tdata  = {2'b00, w_cells[0].idx, w_cells[0].data};
    assign o_m_axis_tlast  = w_cells[0].last;
    assign o_m_axis_tuser  = w_cells[0].short_flag;

endmodule

[rtl/core/uihb_checker.sv]
// port-level checks for the header builder and their bind
module uihb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    logic w_take;

    assign w_take = o_m_axis_tvalid & i_m_axis_tready;

    // stalled output request holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output request changed while stalled");

    // bytes of one header follow with no gap and rising index
    a_next_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid &&
             o_m_axis_tdata[13:8] == $past(o_m_axis_tdata[13:8]) + 6'd1))
        else $error("header byte index did not advance");

    // a new header starts at index zero
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_m_axis_tlast) |=> (!o_m_axis_tvalid || o_m_axis_tdata[13:8] == 6'd0))
        else $error("header did not start at index zero");

    // last byte is at index 41 or 45 only
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata[13:8] == 6'd41 || o_m_axis_tdata[13:8] == 6'd45))
        else $error("last byte at unexpected index");

    // short flag is the same on all bytes of one header
    a_flag_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !o_m_axis_tlast) |=> (o_m_axis_tuser == $past(o_m_axis_tuser)))
        else $error("short flag changed inside a header");

endmodule

bind udp_ipv4_header_builder uihb_checker u_uihb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[tb/testbench.sv]
// self-checking testbench for the udp/ipv4 header builder, stream and apb driven
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;   // cycles without any request taken
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 32;

    // one header byte as the sink should see it
    typedef struct packed {
        logic [7:0] hbyte;
        logic [5:0] idx;
        logic       last;
        logic       short_flag;
    } t_hdr_byte;

    // receiver ready patterns
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_THIRD,
        RX_BURSTY
    } t_rx_mode;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic [63:0] prdata;
    logic        pready;

    // register shadow, starts at the reset values of the block
    uihb_pkg::t_cfg cfg_shadow = '{
        dst_mac:      uihb_pkg::RST_DST_MAC,
        src_mac:      uihb_pkg::RST_SRC_MAC,
        ip_addresses: uihb_pkg::RST_IP_ADDRESSES,
        udp_ports:    uihb_pkg::RST_UDP_PORTS,
        ttl_tos:      uihb_pkg::RST_TTL_TOS,
        vlan_enable:  uihb_pkg::RST_VLAN_ENABLE,
        vlan_pcp:     uihb_pkg::RST_VLAN_PCP,
        vlan_id:      uihb_pkg::RST_VLAN_ID
    };

    logic [15:0] frame_len_q[$];     // frame lengths waiting to be sent
    t_hdr_byte   expected_bytes[$];  // header bytes predicted, oldest first

    logic     in_taken = 1'b0;       // request accepted at the last rising edge
    int       burst_left = 1;
    int       gap_left   = 0;
    t_rx_mode rx_mode    = RX_STEADY;
    int       rx_left    = 0;
    int       rx_stall   = 0;

    int quiet_cycles  = 0;
    int mismatches    = 0;
    int frames_sent   = 0;
    int tagged_frames = 0;
    int short_frames  = 0;
    int bytes_checked = 0;

    always #5 clk = ~clk;

    udp_ipv4_header_builder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [15:0] frame length
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [7:0] header_byte, [13:8] byte_index, [15:14] zero
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser),    // [0] too_short
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    // expected header of one frame from the current register shadow
    function automatic void build_header(input logic [15:0] frame_len);
        logic [367:0] wire_bits;     // up to 46 bytes, first wire byte on top
        logic [159:0] ip_hdr;
        logic [15:0]  l2_len;
        logic [15:0]  hdr_len;
        logic [15:0]  ip_len;
        logic [15:0]  udp_len;
        logic [15:0]  tci;
        logic [15:0]  csum;
        logic [31:0]  src_ip;
        logic [31:0]  dst_ip;
        logic [31:0]  acc;
        logic [7:0]   ttl;
        logic [7:0]   tos;
        logic         is_short;
        t_hdr_byte    b;
        int           k;

        l2_len  = cfg_shadow.vlan_enable ? uihb_pkg::ETH_LEN + uihb_pkg::TAG_LEN
                                         : uihb_pkg::ETH_LEN;
        hdr_len = l2_len + uihb_pkg::IP_LEN + uihb_pkg::UDP_LEN;
        // both lengths are taken modulo 65536 and can wrap when the frame is shorter than the header
        ip_len  = frame_len - l2_len;
        udp_len = ip_len - uihb_pkg::IP_LEN;
        src_ip  = cfg_shadow.ip_addresses[63:32];
        dst_ip  = cfg_shadow.ip_addresses[31:0];
        ttl     = cfg_shadow.ttl_tos[15:8];
        tos     = cfg_shadow.ttl_tos[7:0];
        tci     = {cfg_shadow.vlan_pcp, 1'b0, cfg_shadow.vlan_id};
        is_short = frame_len < hdr_len;

        // ones' complement sum over the ip header words, id/flags/checksum are zero
        acc = 32'd0 + {uihb_pkg::VER_IHL, tos} + ip_len + {ttl, uihb_pkg::PROTO_UDP}
            + src_ip[31:16] + src_ip[15:0] + dst_ip[31:16] + dst_ip[15:0];
        while (acc[31:16] != 16'd0)
            acc = acc[15:0] + acc[31:16];
        csum = ~acc[15:0];

        ip_hdr = {uihb_pkg::VER_IHL, tos, ip_len, 16'h0000, 16'h0000, ttl,
                  uihb_pkg::PROTO_UDP, csum, src_ip, dst_ip};
        if (cfg_shadow.vlan_enable) begin
            wire_bits = {cfg_shadow.dst_mac, cfg_shadow.src_mac, uihb_pkg::TPID_TAG, tci,
                         uihb_pkg::TYPE_IPV4, ip_hdr, cfg_shadow.udp_ports, udp_len,
                         16'h0000};
            tagged_frames++;
        end else begin
            wire_bits = {cfg_shadow.dst_mac, cfg_shadow.src_mac, uihb_pkg::TYPE_IPV4,
                         ip_hdr, cfg_shadow.udp_ports, udp_len, 16'h0000, 32'h0};
        end
        if (is_short)
            short_frames++;
        frames_sent++;

        for (k = 0; k < hdr_len; k++) begin
            b.hbyte      = wire_bits[367 - 8*k -: 8];
            b.idx        = k[5:0];
            b.last       = (k == hdr_len - 1);
            b.short_flag = is_short;
            expected_bytes.push_back(b);
        end
    endfunction

    // apb write: setup cycle, then access cycle, register taken at the edge that ends the access cycle
    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // shadow keeps only the bits the register holds
        case (index)
            uihb_pkg::REG_DST_MAC:      cfg_shadow.dst_mac      = value[47:0];
            uihb_pkg::REG_SRC_MAC:      cfg_shadow.src_mac      = value[47:0];
            uihb_pkg::REG_IP_ADDRESSES: cfg_shadow.ip_addresses = value;
            uihb_pkg::REG_UDP_PORTS:    cfg_shadow.udp_ports    = value[31:0];
            uihb_pkg::REG_TTL_TOS:      cfg_shadow.ttl_tos      = value[15:0];
            uihb_pkg::REG_VLAN_ENABLE:  cfg_shadow.vlan_enable  = value[0];
            uihb_pkg::REG_VLAN_PCP:     cfg_shadow.vlan_pcp     = value[2:0];
            uihb_pkg::REG_VLAN_ID:      cfg_shadow.vlan_id      = value[11:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [63:0] fill, input logic vlan_on);
        write_reg(uihb_pkg::REG_DST_MAC, fill);
        write_reg(uihb_pkg::REG_SRC_MAC, fill);
        write_reg(uihb_pkg::REG_IP_ADDRESSES, fill);
        write_reg(uihb_pkg::REG_UDP_PORTS, fill);
        write_reg(uihb_pkg::REG_TTL_TOS, fill);
        write_reg(uihb_pkg::REG_VLAN_ENABLE, {fill[63:1], vlan_on});
        write_reg(uihb_pkg::REG_VLAN_PCP, fill);
        write_reg(uihb_pkg::REG_VLAN_ID, fill);
    endtask

    // sender holds off until every predicted byte has left the block
    task automatic wait_drained;
        do
            @(negedge clk);
        while (frame_len_q.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        // leave margin before touching registers
        repeat (8) @(negedge clk);
    endtask

    // frame length mix: normal frames, sizes near the header length, full range, tiny
    function automatic logic [15:0] pick_frame_len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 16'($urandom_range(42, 1522));
        else if (r < 65)
            return 16'($urandom_range(38, 50));
        else if (r < 85)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(0, 41));
    endfunction

    // sender: bursts of requests with random gaps, some stretches back to back
    always @(negedge clk) begin
        if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (frame_len_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= frame_len_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready follows a randomly chosen pattern, picked anew when its run ends
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_THIRD:  m_tready <= (rx_left % 3 == 0);
            default: begin
                // mostly ready with occasional long stalls
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall = $urandom_range(1, 24);
                end
            end
        endcase
    end

    // monitor: predict on every accepted request, check every accepted header byte
    always @(posedge clk) begin : monitor
        t_hdr_byte seen;
        t_hdr_byte want;
        logic      in_fire;
        logic      out_fire;

        in_fire  = rst_n && s_tvalid && s_tready === 1'b1;
        out_fire = rst_n && m_tvalid === 1'b1 && m_tready;
        in_taken <= in_fire;

        if (in_fire)
            build_header(s_tdata);

        if (out_fire) begin
            seen.hbyte      = m_tdata[7:0];
            seen.idx        = m_tdata[13:8];
            seen.last       = m_tlast;
            seen.short_flag = m_tuser;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected header byte %02h idx %0d last %0b short %0b",
                             seen.hbyte, seen.idx, seen.last, seen.short_flag);
            end else begin
                want = expected_bytes.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"header byte mismatch: expected %02h idx %0d last %0b ",
                                  "short %0b, got %02h idx %0d last %0b short %0b"},
                                 want.hbyte, want.idx, want.last, want.short_flag,
                                 seen.hbyte, seen.idx, seen.last, seen.short_flag);
                end
            end
        end

        quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
    end

    // watchdog on a stuck handshake
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no request taken for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int p;
        int n;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, lengths around both header sizes and the field extremes
        frame_len_q = '{16'd0, 16'd1, 16'd41, 16'd42, 16'd43, 16'd45, 16'd46, 16'd47,
                        16'd64, 16'd1500, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
        wait_drained();

        // all-zero registers with the tag on
        write_all_regs(64'h0, 1'b1);
        @(posedge clk);
        frame_len_q = '{16'd0, 16'd18, 16'd45, 16'd46, 16'd47, 16'hFFFF};
        wait_drained();

        // all-one registers, upper bits of each write must be dropped
        write_all_regs({64{1'b1}}, 1'b1);
        @(posedge clk);
        frame_len_q = '{16'd46, 16'd0, 16'd100, 16'hFFFF};
        wait_drained();

        // random register settings, tag on or off at random in each phase
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(uihb_pkg::REG_DST_MAC,      {$urandom, $urandom});
            write_reg(uihb_pkg::REG_SRC_MAC,      {$urandom, $urandom});
            write_reg(uihb_pkg::REG_IP_ADDRESSES, {$urandom, $urandom});
            write_reg(uihb_pkg::REG_UDP_PORTS,    {$urandom, $urandom});
            write_reg(uihb_pkg::REG_TTL_TOS,      {$urandom, $urandom});
            write_reg(uihb_pkg::REG_VLAN_ENABLE,  {$urandom, $urandom} ^ 64'(p % 2));
            write_reg(uihb_pkg::REG_VLAN_PCP,     {$urandom, $urandom});
            write_reg(uihb_pkg::REG_VLAN_ID,      {$urandom, $urandom});
            @(posedge clk);
            for (n = 0; n < PHASE_ITEMS; n++)
                frame_len_q.push_back(pick_frame_len());
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            mismatches++;
            $display("%0d header bytes never arrived", expected_bytes.size());
        end

        $display("covered %0d frames (%0d tagged, %0d shorter than the header), %0d bytes",
                 frames_sent, tagged_frames, short_frames, bytes_checked);
        $display("register sets: reset, all zero, all one and %0d random", RANDOM_PHASES);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
